@@ hdl/rsamp_pkg.sv @@
// ----------------------------------------------------------------------------
// rsamp_pkg: shared types and constants of the modular power block
// Word width, register indexes, sequencer states and the request and
// response bundles of the shared modular multiplier.
// ----------------------------------------------------------------------------
package rsamp_pkg;

    // Width of data words, modulus and exponent.
    localparam int WORD_BITS = 16;

    // Bits of the multiplier step counter and of the configuration index.
    localparam int CNT_BITS     = $clog2(WORD_BITS);
    localparam int CFG_IDX_BITS = 1;

    typedef logic [WORD_BITS-1:0]    t_word;
    typedef logic [WORD_BITS+1:0]    t_ext;
    typedef logic [CNT_BITS-1:0]     t_cnt;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_index;

    // Configuration register indexes.
    localparam t_cfg_index CFG_MODULUS  = t_cfg_index'(0);
    localparam t_cfg_index CFG_EXPONENT = t_cfg_index'(1);

    // Reset values of the configuration registers.
    localparam t_word MODULUS_RESET  = t_word'(2);
    localparam t_word EXPONENT_RESET = t_word'(1);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MULT,
        ST_SQUARE,
        ST_DONE
    } t_state;

    // Request to the modular multiplier: product op_a * op_b mod modulus.
    typedef struct packed {
        logic  start;
        t_word op_a;
        t_word op_b;
    } t_mul_req;

    // Response of the modular multiplier; product is valid while done is high.
    typedef struct packed {
        logic  busy;
        logic  done;
        t_word product;
    } t_mul_rsp;

endpackage

@@ hdl/rsamp_in_if.sv @@
// ----------------------------------------------------------------------------
// rsamp_in_if: input item channel
// Valid/ready channel that carries one data word and its last flag.
// ----------------------------------------------------------------------------
interface rsamp_in_if;

    logic                 valid;
    logic                 ready;
    rsamp_pkg::t_word     data_word;
    logic                 last_word;

    modport source (output valid, output data_word, output last_word, input ready);
    modport sink   (input valid, input data_word, input last_word, output ready);

endinterface

@@ hdl/rsamp_out_if.sv @@
// ----------------------------------------------------------------------------
// rsamp_out_if: result item channel
// Valid/ready channel that carries one result word and its last flag.
// ----------------------------------------------------------------------------
interface rsamp_out_if;

    logic                 valid;
    logic                 ready;
    rsamp_pkg::t_word     result_word;
    logic                 last_out;

    modport source (output valid, output result_word, output last_out, input ready);
    modport sink   (input valid, input result_word, input last_out, output ready);

endinterface

@@ hdl/rsamp_modmul.sv @@
// ----------------------------------------------------------------------------
// rsamp_modmul: bit-serial modular multiplier
// Interleaved shift-add-reduce: one bit of op_b per cycle, MSB first, with
// the partial result kept below the modulus. Operand op_a must be below the
// modulus and the modulus at least two.
// ----------------------------------------------------------------------------
module rsamp_modmul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsamp_pkg::t_mul_req i_req,
    input  rsamp_pkg::t_word    i_modulus,
    output rsamp_pkg::t_mul_rsp o_rsp
);

    localparam int MSB = rsamp_pkg::WORD_BITS - 1;

    logic             r_busy;
    logic             r_done;
    rsamp_pkg::t_cnt  r_cnt;
    rsamp_pkg::t_word r_a;
    rsamp_pkg::t_word r_b;
    rsamp_pkg::t_word r_acc;

    rsamp_pkg::t_ext  sum;
    rsamp_pkg::t_ext  ext_mod;
    rsamp_pkg::t_ext  red1;
    rsamp_pkg::t_ext  red2;
    rsamp_pkg::t_word n_acc;

    // One step: acc = 2*acc + bit*a, then at most two subtractions of m,
    // since 2*acc + a stays below three times the modulus.
    always_comb begin
        ext_mod = {2'b00, i_modulus};
        sum     = {1'b0, r_acc, 1'b0} + (r_b[MSB] ? {2'b00, r_a} : '0);
        red1    = (sum >= ext_mod) ? (sum - ext_mod) : sum;
        red2    = (red1 >= ext_mod) ? (red1 - ext_mod) : red1;
        n_acc   = red2[MSB:0];
    end

    // Control: busy while the steps run, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.op_a;
            r_b   <= i_req.op_b;
            r_acc <= '0;
            r_cnt <= rsamp_pkg::t_cnt'(rsamp_pkg::WORD_BITS - 1);
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[MSB-1:0], 1'b0};
            r_cnt <= r_cnt - rsamp_pkg::t_cnt'(1);
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

@@ hdl/rsa_modular_power.sv @@
// ----------------------------------------------------------------------------
// rsa_modular_power: modular exponentiation for textbook RSA
// Each input item x gives x to the key exponent modulo the modulus, by
// right-to-left square-and-multiply on one shared bit-serial multiplier.
//
//   channel  dir  handshake         payload
//   i_in     in   valid / ready     data_word[15:0], last_word
//   o_out    out  valid / ready     result_word[15:0], last_out
//   cfg      in   i_cfg_we          i_cfg_index (0 modulus, 1 exponent), i_cfg_data
//
// One item at a time: i_in.ready is high only while the sequencer is idle.
// Each multiplier operation holds its state until the done pulse; an item costs
// one reduction, one square per exponent bit below the top set bit, one multiply
// per set bit, one check per bit, a done state and an idle state.
// Exponent zero or modulus below two skip the multiplier and go straight to
// the done state. A finished result waits in the output register, so a
// stalled o_out does not keep the next item from being accepted. Reset is
// synchronous and restores modulus 2 and exponent 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rsa_modular_power (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  rsamp_pkg::t_cfg_index i_cfg_index,
    input  rsamp_pkg::t_word      i_cfg_data,
    rsamp_in_if.sink              i_in,
    rsamp_out_if.source           o_out
);

    localparam int MSB = rsamp_pkg::WORD_BITS - 1;

    rsamp_pkg::t_state r_state;
    rsamp_pkg::t_state n_state;

    rsamp_pkg::t_word  r_modulus;
    rsamp_pkg::t_word  r_key_exponent;

    rsamp_pkg::t_word  r_exp;
    rsamp_pkg::t_word  n_exp;
    rsamp_pkg::t_word  r_acc;
    rsamp_pkg::t_word  n_acc;
    rsamp_pkg::t_word  r_base;
    rsamp_pkg::t_word  n_base;
    logic              r_last;
    logic              n_last;

    logic              r_out_valid;
    logic              n_out_valid;
    rsamp_pkg::t_word  r_out_word;
    rsamp_pkg::t_word  n_out_word;
    logic              r_out_last;
    logic              n_out_last;

    logic              in_accept;
    logic              out_free;
    logic              trivial;

    rsamp_pkg::t_mul_req mul_req;
    rsamp_pkg::t_mul_rsp mul_rsp;

    assign in_accept = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign trivial   = (r_key_exponent == '0) || (r_modulus < rsamp_pkg::t_word'(2));

    // Shared modular multiplier.
    rsamp_modmul u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mul_req),
        .i_modulus (r_modulus),
        .o_rsp     (mul_rsp)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus      <= rsamp_pkg::MODULUS_RESET;
            r_key_exponent <= rsamp_pkg::EXPONENT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rsamp_pkg::CFG_MODULUS:  r_modulus      <= i_cfg_data;
                rsamp_pkg::CFG_EXPONENT: r_key_exponent <= i_cfg_data;
                default:                 ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsamp_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = trivial ? rsamp_pkg::ST_DONE : rsamp_pkg::ST_REDUCE;
                end
            end
            rsamp_pkg::ST_REDUCE: begin
                if (mul_rsp.done) n_state = rsamp_pkg::ST_CHECK;
            end
            rsamp_pkg::ST_CHECK: begin
                priority if (r_exp == '0) n_state = rsamp_pkg::ST_DONE;
                else if (r_exp[0])        n_state = rsamp_pkg::ST_MULT;
                else                      n_state = rsamp_pkg::ST_SQUARE;
            end
            rsamp_pkg::ST_MULT: begin
                if (mul_rsp.done) begin
                    n_state = (r_exp[MSB:1] == '0) ? rsamp_pkg::ST_DONE
                                                   : rsamp_pkg::ST_SQUARE;
                end
            end
            rsamp_pkg::ST_SQUARE: begin
                if (mul_rsp.done) n_state = rsamp_pkg::ST_CHECK;
            end
            rsamp_pkg::ST_DONE: begin
                if (out_free) n_state = rsamp_pkg::ST_IDLE;
            end
            default: n_state = rsamp_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier requests and datapath updates.
    always_comb begin
        n_exp         = r_exp;
        n_acc         = r_acc;
        n_base        = r_base;
        n_last        = r_last;
        n_out_word    = r_out_word;
        n_out_last    = r_out_last;
        n_out_valid   = r_out_valid && !o_out.ready;
        mul_req.start = 1'b0;
        mul_req.op_a  = r_base;
        mul_req.op_b  = r_base;
        unique case (r_state)
            rsamp_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_last = i_in.last_word;
                    n_exp  = r_key_exponent;
                    priority if (r_key_exponent == '0) begin
                        n_acc = rsamp_pkg::t_word'(1);
                    end else if (r_modulus < rsamp_pkg::t_word'(2)) begin
                        n_acc = '0;
                    end else begin
                        // Reduce the data word below the modulus as 1 * x mod m.
                        mul_req.start = 1'b1;
                        mul_req.op_a  = rsamp_pkg::t_word'(1);
                        mul_req.op_b  = i_in.data_word;
                    end
                end
            end
            rsamp_pkg::ST_REDUCE: begin
                if (mul_rsp.done) begin
                    n_base = mul_rsp.product;
                    n_acc  = rsamp_pkg::t_word'(1);
                end
            end
            rsamp_pkg::ST_CHECK: begin
                if (r_exp != '0) begin
                    mul_req.start = 1'b1;
                    if (r_exp[0]) mul_req.op_a = r_acc;
                end
            end
            rsamp_pkg::ST_MULT: begin
                if (mul_rsp.done) begin
                    n_acc = mul_rsp.product;
                    // Square only while higher exponent bits remain.
                    if (r_exp[MSB:1] != '0) mul_req.start = 1'b1;
                end
            end
            rsamp_pkg::ST_SQUARE: begin
                if (mul_rsp.done) begin
                    n_base = mul_rsp.product;
                    n_exp  = {1'b0, r_exp[MSB:1]};
                end
            end
            rsamp_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_acc;
                    n_out_last  = r_last;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsamp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_exp      <= n_exp;
        r_acc      <= n_acc;
        r_base     <= n_base;
        r_last     <= n_last;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
    end

    assign i_in.ready        = (r_state == rsamp_pkg::ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.result_word = r_out_word;
    assign o_out.last_out    = r_out_last;

    // A new request never reaches the multiplier while it is still busy.
    a_start_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    // A multiplier result appears only in a state that waits for one.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == rsamp_pkg::ST_REDUCE ||
                          r_state == rsamp_pkg::ST_MULT ||
                          r_state == rsamp_pkg::ST_SQUARE))
        else $error("multiplier result outside a wait state");

    // An accepted item blocks the input for at least the next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !i_in.ready)
        else $error("second item accepted during work");

endmodule
